// ===== sv/piarb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package piarb_pkg;

  // Default fixed-point and phase resolution.
  localparam int FRACTION_BITS_DEF = 12;
  localparam int PHASE_BITS_DEF    = 32;

  // Field widths.
  localparam int MV_W       = 12;
  localparam int GAIN_W     = 16;
  localparam int ERR_W      = 13;
  localparam int DAC_W      = 8;
  localparam int STEP_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Product of a signed gain difference and a signed error.
  localparam int PROD_W = GAIN_W + 1 + ERR_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN_TS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 3'd5;

  // Register reset values.
  localparam logic [STEP_W-1:0] RST_PHASE_STEP  = 32'd42949673;
  localparam logic [MV_W-1:0]   RST_SETPOINT    = 12'd1000;
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN   = 16'd410;
  localparam logic [GAIN_W-1:0] RST_INT_GAIN_TS = 16'd41;
  localparam logic [MV_W-1:0]   RST_LOWER_LIMIT = 12'd142;
  localparam logic [MV_W-1:0]   RST_UPPER_LIMIT = 12'd3300;

  // DAC scaling: code = floor(acc * 255 / (3300 * 2^F)), capped at 255.
  localparam int DAC_MAX         = 255;
  localparam int DAC_FS_MV       = 3300;
  localparam int SCALED_W        = MV_W + 8;
  localparam int DAC_SAT_T       = (DAC_MAX + 1) * DAC_FS_MV;
  localparam int RECIP_W         = 21;
  localparam int DAC_RECIP_SHIFT = 32;
  // ceil(2^32 / 3300); exact for every scaled value below DAC_SAT_T.
  localparam logic [RECIP_W-1:0] DAC_RECIP = 21'd1301506;

endpackage

`default_nettype wire

// ===== sv/piarb_dac_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

module piarb_dac_scale #(
  parameter int FRACTION_BITS = piarb_pkg::FRACTION_BITS_DEF
) (
  input  logic [piarb_pkg::MV_W+FRACTION_BITS-1:0] acc_i,
  output logic [piarb_pkg::DAC_W-1:0]              dac_code_o
);
  import piarb_pkg::*;

  localparam int ACC_W = MV_W + FRACTION_BITS;

  logic [ACC_W+7:0]            times_255;
  logic [SCALED_W-1:0]         scaled;
  logic [SCALED_W+RECIP_W-1:0] recip_prod;

  // acc * 255 as a shift and a subtract, then drop the fraction bits.
  assign times_255  = {acc_i, 8'd0} - {8'd0, acc_i};
  assign scaled     = times_255[ACC_W+7:FRACTION_BITS];
  assign recip_prod = (SCALED_W+RECIP_W)'(scaled) * (SCALED_W+RECIP_W)'(DAC_RECIP);

  always_comb begin
    if (scaled >= SCALED_W'(DAC_SAT_T)) begin
      dac_code_o = DAC_W'(DAC_MAX);
    end else begin
      dac_code_o = recip_prod[DAC_RECIP_SHIFT+DAC_W-1:DAC_RECIP_SHIFT];
    end
  end

endmodule

`default_nettype wire

// ===== sv/pi_amplitude_regulator_bridge_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted item waits in the input register and moves into the result register once that
// register is empty or its item is being taken. Throughput: one item per cycle unless
// m_axis_tready stalls the result; the controller state updates in one pass per item.
// The PI update, phase step and bridge polarity are all settled between the two registers.
// Reset (rst_ni low, asynchronous) clears the pipeline, loads the register defaults,
// zeroes phase, command and previous error, turns both legs off and arms the half-cycle flag.

module pi_amplitude_regulator_bridge_unit #(
  parameter int FRACTION_BITS = piarb_pkg::FRACTION_BITS_DEF,
  parameter int PHASE_BITS    = piarb_pkg::PHASE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [piarb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [piarb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Sample input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, from bit 0: volt_pos_mv[11:0], volt_neg_mv[11:0].
  input  logic [piarb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, from bit 0: dac_code[7:0], drive_high_leg, drive_low_leg, error_mv[12:0],
  // command_mv[11:0], saturated, then four zero bits.
  output logic [piarb_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import piarb_pkg::*;

  localparam int ACC_W = MV_W + FRACTION_BITS;
  localparam int SUM_W = ((ACC_W + 1 > PROD_W) ? ACC_W + 1 : PROD_W) + 2;
  localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

  // Configuration registers.
  logic [STEP_W-1:0] phase_step_q;
  logic [MV_W-1:0]   setpoint_q;
  logic [GAIN_W-1:0] prop_gain_q;
  logic [GAIN_W-1:0] int_gain_q;
  logic [MV_W-1:0]   lower_limit_q;
  logic [MV_W-1:0]   upper_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= RST_PHASE_STEP;
      setpoint_q    <= RST_SETPOINT;
      prop_gain_q   <= RST_PROP_GAIN;
      int_gain_q    <= RST_INT_GAIN_TS;
      lower_limit_q <= RST_LOWER_LIMIT;
      upper_limit_q <= RST_UPPER_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PHASE_STEP:  phase_step_q  <= cfg_wdata_i[STEP_W-1:0];
        CFG_SETPOINT:    setpoint_q    <= cfg_wdata_i[MV_W-1:0];
        CFG_PROP_GAIN:   prop_gain_q   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_INT_GAIN_TS: int_gain_q    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_LOWER_LIMIT: lower_limit_q <= cfg_wdata_i[MV_W-1:0];
        CFG_UPPER_LIMIT: upper_limit_q <= cfg_wdata_i[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake. The input register moves into the result register when the
  // result register is empty or its item is being taken this cycle.
  logic in_valid_q;
  logic out_valid_q;
  logic advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;

  logic [MV_W-1:0] pos_q;
  logic [MV_W-1:0] neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      pos_q <= s_axis_tdata[MV_W-1:0];
      neg_q <= s_axis_tdata[2*MV_W-1:MV_W];
    end
  end

  // Controller state.
  logic [PHASE_BITS-1:0]   phase_q;
  logic                    half_flag_q;
  logic [1:0]              leg_q;
  logic signed [ERR_W-1:0] prev_err_q;
  logic [ACC_W-1:0]        acc_q;
  logic                    integ_en_q;

  // Phase and bridge polarity. The sine is zero at phase zero and at half scale,
  // where the bridge keeps its state.
  logic [PHASE_BITS-1:0] phase_d;
  logic                  sine_pos;
  logic                  sine_neg;
  logic                  half_flag_d;
  logic [1:0]            leg_d;

  assign phase_d  = phase_q + PHASE_BITS'(phase_step_q);
  assign sine_pos = (phase_d != '0) && (phase_d < PHASE_HALF);
  assign sine_neg = phase_d > PHASE_HALF;

  always_comb begin
    half_flag_d = half_flag_q;
    leg_d       = leg_q;
    if (half_flag_q && sine_pos) begin
      leg_d       = 2'b01;
      half_flag_d = 1'b0;
    end else if (!half_flag_q && sine_neg) begin
      leg_d       = 2'b10;
      half_flag_d = 1'b1;
    end
  end

  // Error: setpoint minus the magnitude of the pole difference.
  logic [MV_W-1:0]         diff_mag;
  logic signed [ERR_W-1:0] err;

  assign diff_mag = (pos_q >= neg_q) ? (pos_q - neg_q) : (neg_q - pos_q);
  assign err      = signed'({1'b0, setpoint_q}) - signed'({1'b0, diff_mag});

  // Incremental PI update. Integration is suspended for the next item after a clamp.
  logic [GAIN_W-1:0]        ki_eff;
  logic signed [GAIN_W:0]   kp_s;
  logic signed [GAIN_W:0]   k_diff;
  logic signed [PROD_W-1:0] p_term;
  logic signed [PROD_W-1:0] i_term;
  logic signed [SUM_W-1:0]  u_sum;
  logic signed [SUM_W-1:0]  upper_fx;
  logic signed [SUM_W-1:0]  lower_fx;
  logic signed [SUM_W-1:0]  u_new;
  logic                     sat;

  assign ki_eff   = integ_en_q ? int_gain_q : '0;
  assign kp_s     = signed'({1'b0, prop_gain_q});
  assign k_diff   = signed'({1'b0, ki_eff}) - kp_s;
  assign p_term   = kp_s * err;
  assign i_term   = k_diff * prev_err_q;
  assign u_sum    = SUM_W'(signed'({1'b0, acc_q})) + SUM_W'(p_term) + SUM_W'(i_term);
  assign upper_fx = SUM_W'(signed'({1'b0, upper_limit_q, {FRACTION_BITS{1'b0}}}));
  assign lower_fx = SUM_W'(signed'({1'b0, lower_limit_q, {FRACTION_BITS{1'b0}}}));

  // The upper limit is tested first, so it wins where a sum breaks both limits.
  always_comb begin
    u_new = u_sum;
    sat   = 1'b0;
    if (u_sum > upper_fx) begin
      u_new = upper_fx;
      sat   = 1'b1;
    end else if (u_sum < lower_fx) begin
      u_new = lower_fx;
      sat   = 1'b1;
    end
  end

  // The DAC code reflects the command held before this item.
  logic [DAC_W-1:0] dac_code;

  piarb_dac_scale #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dac_scale (
    .acc_i      (acc_q),
    .dac_code_o (dac_code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      half_flag_q <= 1'b1;
      leg_q       <= 2'b00;
      prev_err_q  <= '0;
      acc_q       <= '0;
      integ_en_q  <= 1'b1;
    end else if (advance) begin
      phase_q     <= phase_d;
      half_flag_q <= half_flag_d;
      leg_q       <= leg_d;
      prev_err_q  <= err;
      acc_q       <= u_new[ACC_W-1:0];
      integ_en_q  <= !sat;
    end
  end

  // Result register.
  logic [DAC_W-1:0]        dac_q;
  logic [1:0]              out_leg_q;
  logic signed [ERR_W-1:0] out_err_q;
  logic [MV_W-1:0]         out_cmd_q;
  logic                    out_sat_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dac_q     <= dac_code;
      out_leg_q <= leg_d;
      out_err_q <= err;
      out_cmd_q <= u_new[FRACTION_BITS+MV_W-1:FRACTION_BITS];
      out_sat_q <= sat;
    end
  end

  assign m_axis_tdata = {4'd0, out_sat_q, out_cmd_q, out_err_q, out_leg_q[1], out_leg_q[0],
                         dac_q};

  // The anti-windup flag always matches the clamp of the item on display.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (integ_en_q == !out_sat_q))
    else $error("integrate enable disagrees with saturated result");

  // At most one bridge leg is driven.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(leg_q))
    else $error("both bridge legs driven");

  // The half-cycle flag waits for the half opposite to the leg being driven.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((leg_q == 2'b01) |-> !half_flag_q) and ((leg_q == 2'b10) |-> half_flag_q))
    else $error("half-cycle flag out of step with bridge legs");

  // An empty result register never holds off the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire
